>>> design/rlps_pkg.sv
package rlps_pkg;

  // Data bits per pixel and the width of the bit counter that holds them
  localparam int unsigned DATA_BITS = 24;
  localparam int unsigned CNT_W     = $clog2(DATA_BITS + 1);

  // Queue between front and back; depth must be a power of two
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    SYM_ZERO  = 2'd0,
    SYM_ONE   = 2'd1,
    SYM_RESET = 2'd2
  } sym_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_START,
    BK_DATA,
    BK_END
  } bk_state_t;

  // Scaled pixel in line order plus its framing flags
  typedef struct packed {
    logic [DATA_BITS-1:0] grb;
    logic                 frame_start;
    logic                 frame_end;
  } pix_t;

  // Handshake between queue and back end
  typedef struct packed {
    logic valid;
    logic take;
  } q_hs_t;

endpackage

>>> design/rlps_front.sv
module rlps_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      in_green,
  input  logic [7:0]      in_red,
  input  logic [7:0]      in_blue,
  input  logic [7:0]      in_brightness,
  input  logic            in_frame_start,
  input  logic            in_frame_end,
  output logic            q_push,
  input  logic            q_full,
  output rlps_pkg::pix_t  q_wdata
);

  logic           valid_r, valid_nxt;
  rlps_pkg::pix_t pix_r, pix_nxt;
  logic           load;
  logic [15:0]    g_prod, r_prod, b_prod;

  assign g_prod = 16'(in_green) * 16'(in_brightness);
  assign r_prod = 16'(in_red)   * 16'(in_brightness);
  assign b_prod = 16'(in_blue)  * 16'(in_brightness);

  assign full   = valid_r && q_full;
  assign load   = push && !full;
  assign q_push = valid_r && !q_full;
  assign q_wdata = pix_r;

  always_comb begin
    valid_nxt = valid_r;
    pix_nxt   = pix_r;
    if (q_push) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt           = 1'b1;
      pix_nxt.grb         = {g_prod[15:8], r_prod[15:8], b_prod[15:8]};
      pix_nxt.frame_start = in_frame_start;
      pix_nxt.frame_end   = in_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    pix_r <= pix_nxt;
  end

endmodule

>>> design/rlps_queue.sv
module rlps_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_push,
  output logic            q_full,
  input  rlps_pkg::pix_t  q_wdata,
  output rlps_pkg::q_hs_t q_hs_out,
  input  logic            q_take,
  output rlps_pkg::pix_t  q_rdata
);

  rlps_pkg::pix_t                  mem [rlps_pkg::QDEPTH];
  logic [rlps_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [rlps_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign q_full  = (cnt_r == rlps_pkg::QCNT_W'(rlps_pkg::QDEPTH));
  assign do_push = q_push && !q_full;
  assign do_pop  = q_take && (cnt_r != '0);

  assign q_hs_out.valid = (cnt_r != '0);
  assign q_hs_out.take  = do_pop;
  assign q_rdata        = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

>>> design/rlps_back.sv
module rlps_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_take,
  input  rlps_pkg::pix_t q_rdata,
  output logic           empty,
  input  logic           pop,
  output logic [1:0]     out_symbol,
  output logic           out_last
);

  rlps_pkg::bk_state_t              state_r, state_nxt;
  logic [rlps_pkg::DATA_BITS-1:0]   shift_r, shift_nxt;
  logic [rlps_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             end_r, end_nxt;
  logic                             ovalid_r, ovalid_nxt;
  rlps_pkg::sym_t                   osym_r, osym_nxt;
  logic                             olast_r, olast_nxt;

  logic           adv;
  logic           emit;
  logic           finish;
  rlps_pkg::sym_t sym;
  logic           last;

  assign adv        = !ovalid_r || pop;
  assign empty      = !ovalid_r;
  assign out_symbol = osym_r;
  assign out_last   = olast_r;

  always_comb begin
    state_nxt  = state_r;
    shift_nxt  = shift_r;
    cnt_nxt    = cnt_r;
    end_nxt    = end_r;
    emit       = 1'b0;
    finish     = 1'b0;
    sym        = rlps_pkg::SYM_ZERO;
    last       = 1'b0;
    q_take     = 1'b0;

    case (state_r)
      rlps_pkg::BK_IDLE: begin
        finish = 1'b1;
      end
      rlps_pkg::BK_START: begin
        emit = 1'b1;
        sym  = rlps_pkg::SYM_RESET;
        if (adv) begin
          state_nxt = rlps_pkg::BK_DATA;
        end
      end
      rlps_pkg::BK_DATA: begin
        emit = 1'b1;
        sym  = shift_r[rlps_pkg::DATA_BITS-1] ? rlps_pkg::SYM_ONE : rlps_pkg::SYM_ZERO;
        last = (cnt_r == rlps_pkg::CNT_W'(1)) && !end_r;
        if (adv) begin
          shift_nxt = {shift_r[rlps_pkg::DATA_BITS-2:0], 1'b0};
          cnt_nxt   = cnt_r - 1'b1;
          if (cnt_r == rlps_pkg::CNT_W'(1)) begin
            if (end_r) begin
              state_nxt = rlps_pkg::BK_END;
            end else begin
              finish    = 1'b1;
              state_nxt = rlps_pkg::BK_IDLE;
            end
          end
        end
      end
      rlps_pkg::BK_END: begin
        emit = 1'b1;
        sym  = rlps_pkg::SYM_RESET;
        last = 1'b1;
        if (adv) begin
          finish    = 1'b1;
          state_nxt = rlps_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = rlps_pkg::BK_IDLE;
      end
    endcase

    // Load the next pixel while idle, or in the cycle the current one sends its final symbol
    if (finish && q_valid) begin
      q_take    = 1'b1;
      shift_nxt = q_rdata.grb;
      cnt_nxt   = rlps_pkg::CNT_W'(rlps_pkg::DATA_BITS);
      end_nxt   = q_rdata.frame_end;
      state_nxt = q_rdata.frame_start ? rlps_pkg::BK_START : rlps_pkg::BK_DATA;
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    osym_nxt   = osym_r;
    olast_nxt  = olast_r;
    if (adv) begin
      ovalid_nxt = emit;
      osym_nxt   = sym;
      olast_nxt  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rlps_pkg::BK_IDLE;
      cnt_r    <= '0;
      end_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      end_r    <= end_nxt;
      ovalid_r <= ovalid_nxt;
    end
    shift_r <= shift_nxt;
    osym_r  <= osym_nxt;
    olast_r <= olast_nxt;
  end

endmodule

>>> design/rgb_led_pixel_serializer.sv
// Pixel-to-line-symbol serializer for GRB addressable LEDs. Each pushed pixel is
// scaled by its brightness ((colour*brightness)>>8), then sent as 24 bit symbols,
// green, red, blue, MSB first, with a reset symbol before it if frame_start and
// after it if frame_end; out_last marks the pixel's final symbol. The back-end
// shifter sends one symbol per cycle while pop keeps the output moving; pixels
// follow with no gap when the queue already holds the next. A pixel passes the
// scaling register, the two-entry queue, the state/shift and output registers
// before its first symbol shows. Symbol word timing belongs to the line stage.
module rgb_led_pixel_serializer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_green,
  input  logic [7:0] in_red,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_brightness,
  input  logic       in_frame_start,
  input  logic       in_frame_end,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_symbol,
  output logic       out_last
);

  logic            q_push;
  logic            q_full;
  rlps_pkg::pix_t  q_wdata;
  rlps_pkg::pix_t  q_rdata;
  rlps_pkg::q_hs_t q_hs;
  logic            q_take;

  rlps_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_green       (in_green),
    .in_red         (in_red),
    .in_blue        (in_blue),
    .in_brightness  (in_brightness),
    .in_frame_start (in_frame_start),
    .in_frame_end   (in_frame_end),
    .q_push         (q_push),
    .q_full         (q_full),
    .q_wdata        (q_wdata)
  );

  rlps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_wdata  (q_wdata),
    .q_hs_out (q_hs),
    .q_take   (q_take),
    .q_rdata  (q_rdata)
  );

  rlps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_hs.valid),
    .q_take     (q_take),
    .q_rdata    (q_rdata),
    .empty      (empty),
    .pop        (pop),
    .out_symbol (out_symbol),
    .out_last   (out_last)
  );

  a_take_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_hs.valid)
    else $error("back end took a word from an empty queue");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("front end pushed into a full queue");

  a_data_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_symbol == rlps_pkg::SYM_RESET && !out_last) |=> !empty)
    else $error("leading reset symbol not followed by a data bit");

endmodule
